@@ hw/rtl/atu_pkg.sv @@
// Shared types, constants and the digit decode for the ASCII-to-unsigned parser.
// No dependencies; every other file imports this package.
package atu_pkg;

  localparam int unsigned CH_W          = 8;
  localparam int unsigned VALUE_W       = 32;
  localparam int unsigned OFFSET_W      = 13;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned RADIX_W       = 6;
  localparam int unsigned MAX_CHARS_DEF = 4096;

  localparam logic [RADIX_W-1:0] RADIX_AUTO = 6'd0;
  localparam logic [RADIX_W-1:0] RADIX_BAD  = 6'd1;
  localparam logic [RADIX_W-1:0] RADIX_OCT  = 6'd8;
  localparam logic [RADIX_W-1:0] RADIX_DEC  = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_HEX  = 6'd16;
  localparam logic [RADIX_W-1:0] BASE_LIMIT = 6'd36;
  localparam logic [RADIX_W-1:0] DIGIT_NONE = 6'd63;

  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CH_W-1:0] CH_UP_X  = 8'h58;
  localparam logic [CH_W-1:0] CH_UP_Z  = 8'h5A;
  localparam logic [CH_W-1:0] CH_LO_A  = 8'h61;
  localparam logic [CH_W-1:0] CH_LO_X  = 8'h78;
  localparam logic [CH_W-1:0] CH_LO_Z  = 8'h7A;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WS,
    PH_SIGNED,
    PH_ZERO,
    PH_XPFX,
    PH_DIGITS
  } phase_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_NO_DIGITS,
    ST_BAD_BASE,
    ST_OVERFLOW
  } status_e;

  typedef struct packed {
    logic            valid;
    logic [CH_W-1:0] ch;
    logic            start_req;
  } item_t;

  typedef struct packed {
    logic                valid;
    logic [VALUE_W-1:0]  value;
    logic [OFFSET_W-1:0] end_offset;
    status_e             status;
  } res_t;

  function automatic logic [RADIX_W-1:0] digit_value(input logic [CH_W-1:0] c);
    logic [RADIX_W-1:0] d;
    d = DIGIT_NONE;
    if (c inside {[CH_ZERO:CH_NINE]}) begin
      d = RADIX_W'(c - CH_ZERO);
    end else if (c inside {[CH_LO_A:CH_LO_Z]}) begin
      d = RADIX_W'(c - CH_LO_A) + RADIX_DEC;
    end else if (c inside {[CH_UP_A:CH_UP_Z]}) begin
      d = RADIX_W'(c - CH_UP_A) + RADIX_DEC;
    end
    return d;
  endfunction

endpackage

@@ hw/rtl/atu_if.sv @@
// Channel interfaces of the parser: character requests, results and radix writes.
// Depends on atu_pkg for field widths.
interface atu_in_if import atu_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;
  logic            start_req;

  modport source (output valid, output ch, output start_req, input ready);
  modport sink (input valid, input ch, input start_req, output ready);
endinterface

interface atu_out_if import atu_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [VALUE_W-1:0]  value;
  logic [OFFSET_W-1:0] end_offset;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output value, output end_offset, output status, input ready);
  modport sink (input valid, input value, input end_offset, input status, output ready);
endinterface

interface atu_cfg_if import atu_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [RADIX_W-1:0] radix_select;

  modport source (output valid, output radix_select, input ready);
  modport sink (input valid, input radix_select, output ready);
endinterface

@@ hw/rtl/atu_in_reg.sv @@
// Input register of the parser: captures one character request per cycle unless stalled.
// Depends on atu_pkg and atu_in_if.
module atu_in_reg import atu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  atu_in_if.sink     in_i,
  input  logic       adv_i,
  output item_t      item_o
);

  logic            valid_q, valid_d;
  logic [CH_W-1:0] ch_q;
  logic            start_q;
  logic            load;

  assign in_i.ready = !valid_q || adv_i;
  assign load       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (adv_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ch_q    <= in_i.ch;
      start_q <= in_i.start_req;
    end
  end

  assign item_o = '{valid: valid_q, ch: ch_q, start_req: start_q};

endmodule

@@ hw/rtl/atu_conv.sv @@
// Conversion step: parse state registers and the per-character next-state logic.
// Depends on atu_pkg (phase codes, digit decode, radix constants).
module atu_conv import atu_pkg::*; #(
  parameter int unsigned MAX_CHARS = MAX_CHARS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  item_t              item_i,
  input  logic               adv_i,
  input  logic [RADIX_W-1:0] radix_sel_i,
  output res_t               res_o
);

  localparam int unsigned CntW = $clog2(MAX_CHARS + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_CHARS);
  localparam int unsigned ProdW = VALUE_W + RADIX_W;

  phase_e             phase_q, phase_d;
  logic               neg_q, neg_d;
  logic [RADIX_W-1:0] radix_q, radix_d;
  logic [VALUE_W-1:0] acc_q, acc_d;
  logic               ovf_q, ovf_d;
  logic               seen_q, seen_d;
  logic [CntW-1:0]    cnt_q, cnt_d;

  logic [CntW-1:0]    pos;
  logic [RADIX_W-1:0] dig;
  logic [ProdW-1:0]   prod;
  logic               go;
  logic [CH_W-1:0]    c;

  assign c   = item_i.ch;
  assign dig = digit_value(c);

  always_comb begin
    phase_d = phase_q;
    neg_d   = neg_q;
    radix_d = radix_q;
    acc_d   = acc_q;
    ovf_d   = ovf_q;
    seen_d  = seen_q;
    cnt_d   = cnt_q;
    pos     = cnt_q;
    prod    = '0;
    go      = 1'b0;
    res_o   = '{valid: 1'b0, value: '0, end_offset: '0, status: ST_OK};

    if (adv_i) begin
      go = 1'b1;
      if (item_i.start_req) begin
        neg_d   = 1'b0;
        acc_d   = '0;
        ovf_d   = 1'b0;
        seen_d  = 1'b0;
        cnt_d   = '0;
        radix_d = radix_sel_i;
        phase_d = PH_WS;
        if (radix_sel_i == RADIX_BAD || radix_sel_i > BASE_LIMIT) begin
          res_o   = '{valid: 1'b1, value: '0, end_offset: '0, status: ST_BAD_BASE};
          phase_d = PH_IDLE;
          go      = 1'b0;
        end
      end
      if (phase_d == PH_IDLE) begin
        go = 1'b0;
      end

      if (go) begin
        pos = cnt_d;
        if (cnt_d < CntMax) begin
          cnt_d = cnt_d + 1'b1;
        end

        if (phase_d == PH_WS) begin
          if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
            go = 1'b0;
          end else begin
            phase_d = PH_SIGNED;
            if (c == CH_PLUS || c == CH_MINUS) begin
              neg_d = (c == CH_MINUS);
              go    = 1'b0;
            end
          end
        end

        if (go && phase_d == PH_SIGNED) begin
          if (c == CH_ZERO && (radix_d == RADIX_AUTO || radix_d == RADIX_HEX)) begin
            seen_d  = 1'b1;
            phase_d = PH_ZERO;
            go      = 1'b0;
          end else begin
            if (radix_d == RADIX_AUTO) begin
              radix_d = RADIX_DEC;
            end
            phase_d = PH_DIGITS;
          end
        end else if (go && phase_d == PH_ZERO) begin
          if (c == CH_LO_X || c == CH_UP_X) begin
            phase_d = PH_XPFX;
            go      = 1'b0;
          end else begin
            if (radix_d == RADIX_AUTO) begin
              radix_d = RADIX_OCT;
            end
            phase_d = PH_DIGITS;
          end
        end else if (go && phase_d == PH_XPFX) begin
          go = 1'b0;
          if (dig < RADIX_HEX) begin
            radix_d = RADIX_HEX;
            acc_d   = VALUE_W'(dig);
            phase_d = PH_DIGITS;
          end else begin
            res_o.valid      = 1'b1;
            res_o.end_offset = (pos >= CntMax) ? OFFSET_W'(CntMax) : OFFSET_W'(pos - 1'b1);
            phase_d          = PH_IDLE;
          end
        end

        if (go) begin
          if (dig < radix_d) begin
            prod = ProdW'(acc_d) * ProdW'(radix_d) + ProdW'(dig);
            if (prod[ProdW-1:VALUE_W] != '0) begin
              ovf_d = 1'b1;
            end
            acc_d  = prod[VALUE_W-1:0];
            seen_d = 1'b1;
          end else begin
            res_o.valid = 1'b1;
            phase_d     = PH_IDLE;
            if (!seen_d) begin
              res_o.status = ST_NO_DIGITS;
            end else if (ovf_d) begin
              res_o.value      = '1;
              res_o.end_offset = OFFSET_W'(pos);
              res_o.status     = ST_OVERFLOW;
            end else begin
              res_o.value      = neg_d ? (VALUE_W'(0) - acc_d) : acc_d;
              res_o.end_offset = OFFSET_W'(pos);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      neg_q   <= 1'b0;
      radix_q <= '0;
      acc_q   <= '0;
      ovf_q   <= 1'b0;
      seen_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      neg_q   <= neg_d;
      radix_q <= radix_d;
      acc_q   <= acc_d;
      ovf_q   <= ovf_d;
      seen_q  <= seen_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

@@ hw/rtl/atu_out_reg.sv @@
// Result register of the parser: holds one result until the sink takes it.
// Depends on atu_pkg and atu_out_if.
module atu_out_reg import atu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  res_t       res_i,
  output logic       space_o,
  atu_out_if.source  out_o
);

  logic                valid_q, valid_d;
  logic [VALUE_W-1:0]  value_q;
  logic [OFFSET_W-1:0] offset_q;
  status_e             status_q;

  assign space_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (res_i.valid) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_i.valid) begin
      value_q  <= res_i.value;
      offset_q <= res_i.end_offset;
      status_q <= res_i.status;
    end
  end

  assign out_o.valid      = valid_q;
  assign out_o.value      = value_q;
  assign out_o.end_offset = offset_q;
  assign out_o.status     = status_q;

endmodule

@@ hw/rtl/ascii_to_unsigned_parser_core.sv @@
// Top level of the ASCII-to-unsigned parser: radix register, input register,
// conversion step and result register. Depends on atu_pkg, atu_if and the atu_* modules.
//
//   channel  dir  payload                        handshake
//   in_i     in   ch[7:0], start_req             valid/ready
//   out_o    out  value[31:0], end_offset[12:0], valid/ready
//                 status[1:0]
//   cfg_i    in   radix_select[5:0]              valid/ready, ready always high
//
// One character per cycle while the result register has space; a request passes
// through the input register; its result, if any, is registered in the result register.
// The conversion step is one 32x6 multiply-add between the two registers.
// Reset clears the parse state and sets the radix to automatic; no clearing pass.
// A stalled result register holds the step; the input register still takes one request.
module ascii_to_unsigned_parser_core import atu_pkg::*; #(
  parameter int unsigned MAX_CHARS = MAX_CHARS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  atu_in_if.sink     in_i,
  atu_out_if.source  out_o,
  atu_cfg_if.sink    cfg_i
);

  logic [RADIX_W-1:0] radix_sel_q;
  item_t              item;
  res_t               res;
  logic               space;
  logic               adv;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_sel_q <= RADIX_AUTO;
    end else if (cfg_i.valid) begin
      radix_sel_q <= cfg_i.radix_select;
    end
  end

  assign adv = item.valid && space;

  atu_in_reg u_in_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .adv_i  (adv),
    .item_o (item)
  );

  atu_conv #(
    .MAX_CHARS (MAX_CHARS)
  ) u_conv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item),
    .adv_i       (adv),
    .radix_sel_i (radix_sel_q),
    .res_o       (res)
  );

  atu_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .res_i   (res),
    .space_o (space),
    .out_o   (out_o)
  );

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking bench for ascii_to_unsigned_parser_core: streams strings under several radix
// settings, predicts each conversion, and compares every result field by field.
// Depends on atu_pkg, the atu_* channel interfaces and the parser core.
module tb_top;
  import atu_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_CHARS = 120;
  localparam int BAD_PHASE_CHARS = 30;

  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic [OFFSET_W-1:0] end_offset;
    status_e             status;
  } conversion_t;

  class conversion_scoreboard;
    logic [RADIX_W-1:0] radix_reg;
    logic [RADIX_W-1:0] radix_cur;
    phase_e             phase;
    logic               negative;
    logic               overflowed;
    logic               digit_seen;
    logic [VALUE_W-1:0] acc;
    int unsigned        char_count;
    conversion_t        conversions_due[$];
    int                 errors;

    function new();
      radix_reg  = RADIX_AUTO;
      radix_cur  = RADIX_AUTO;
      phase      = PH_IDLE;
      negative   = 1'b0;
      overflowed = 1'b0;
      digit_seen = 1'b0;
      acc        = '0;
      char_count = 0;
      errors     = 0;
    endfunction

    static function logic [RADIX_W-1:0] char_digit(logic [CH_W-1:0] c);
      logic [CH_W-1:0] lc;
      lc = (c >= CH_UP_A && c <= CH_UP_Z) ? c + 8'd32 : c;
      if (lc >= CH_ZERO && lc <= CH_NINE) return RADIX_W'(lc - CH_ZERO);
      if (lc >= CH_LO_A && lc <= CH_LO_Z) return RADIX_W'(lc - CH_LO_A + 8'd10);
      return DIGIT_NONE;
    endfunction

    function void set_radix(logic [RADIX_W-1:0] r);
      radix_reg = r;
    endfunction

    function int pending();
      return conversions_due.size();
    endfunction

    function void post(logic [VALUE_W-1:0] v, int unsigned off, status_e st);
      conversion_t r;
      r.value      = v;
      r.end_offset = OFFSET_W'(off);
      r.status     = st;
      conversions_due.push_back(r);
      phase = PH_IDLE;
    endfunction

    function void parse_char(logic [CH_W-1:0] c, logic start);
      int unsigned                pos;
      logic [RADIX_W-1:0]         d;
      logic [VALUE_W+RADIX_W:0]   prod;
      if (start) begin
        negative   = 1'b0;
        acc        = '0;
        overflowed = 1'b0;
        digit_seen = 1'b0;
        char_count = 0;
        radix_cur  = radix_reg;
        if (radix_cur == RADIX_BAD || radix_cur > BASE_LIMIT) begin
          post('0, 0, ST_BAD_BASE);
          return;
        end
        phase = PH_WS;
      end
      if (phase == PH_IDLE) return;

      pos = char_count;
      if (char_count < MAX_CHARS_DEF) char_count++;

      if (phase == PH_WS) begin
        if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) return;
        phase = PH_SIGNED;
        if (c == CH_PLUS || c == CH_MINUS) begin
          negative = (c == CH_MINUS);
          return;
        end
      end

      if (phase == PH_SIGNED) begin
        if (c == CH_ZERO && (radix_cur == RADIX_AUTO || radix_cur == RADIX_HEX)) begin
          digit_seen = 1'b1;
          phase = PH_ZERO;
          return;
        end
        if (radix_cur == RADIX_AUTO) radix_cur = RADIX_DEC;
        phase = PH_DIGITS;
      end else if (phase == PH_ZERO) begin
        if (c == CH_LO_X || c == CH_UP_X) begin
          phase = PH_XPFX;
          return;
        end
        if (radix_cur == RADIX_AUTO) radix_cur = RADIX_OCT;
        phase = PH_DIGITS;
      end else if (phase == PH_XPFX) begin
        d = char_digit(c);
        if (d < RADIX_HEX) begin
          radix_cur = RADIX_HEX;
          acc = VALUE_W'(d);
          phase = PH_DIGITS;
          return;
        end
        post('0, (pos >= MAX_CHARS_DEF) ? MAX_CHARS_DEF : pos - 1, ST_OK);
        return;
      end

      d = char_digit(c);
      if (d < radix_cur) begin
        prod = acc * radix_cur + d;
        if (prod[VALUE_W+RADIX_W:VALUE_W] != '0) overflowed = 1'b1;
        acc = prod[VALUE_W-1:0];
        digit_seen = 1'b1;
        return;
      end
      if (!digit_seen) post('0, 0, ST_NO_DIGITS);
      else if (overflowed) post('1, pos, ST_OVERFLOW);
      else post(negative ? -acc : acc, pos, ST_OK);
    endfunction

    function void check_result(logic [VALUE_W-1:0] v, logic [OFFSET_W-1:0] off,
                               logic [STATUS_W-1:0] st);
      conversion_t r;
      if (conversions_due.size() == 0) begin
        $error("result with none due: value %h, end_offset %0d, status %0d", v, off, st);
        errors++;
        return;
      end
      r = conversions_due.pop_front();
      if (v !== r.value) begin
        $error("value: expected %h, got %h", r.value, v);
        errors++;
      end
      if (off !== r.end_offset) begin
        $error("end_offset: expected %0d, got %0d", r.end_offset, off);
        errors++;
      end
      if (st !== r.status) begin
        $error("status: expected %0d, got %0d", r.status, st);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit   hold_off_req;
  int   burst_left;
  conversion_scoreboard sb = new();

  atu_in_if  in_if ();
  atu_out_if out_if ();
  atu_cfg_if cfg_if ();

  ascii_to_unsigned_parser_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic push_char(input logic [CH_W-1:0] c, input logic start);
    bit fired;
    if (burst_left == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    burst_left--;
    in_if.valid     <= 1'b1;
    in_if.ch        <= c;
    in_if.start_req <= start;
    fired = 1'b0;
    while (!fired) begin
      @(negedge clk_i);
      fired = in_if.ready;
      @(posedge clk_i);
    end
    sb.parse_char(c, start);
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i], i == 0);
  endtask

  task automatic write_radix(input logic [RADIX_W-1:0] r);
    bit fired;
    cfg_if.valid        <= 1'b1;
    cfg_if.radix_select <= r;
    fired = 1'b0;
    while (!fired) begin
      @(negedge clk_i);
      fired = cfg_if.ready;
      @(posedge clk_i);
    end
    cfg_if.valid <= 1'b0;
    sb.set_radix(r);
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic send_random_string(input logic [RADIX_W-1:0] radix, output int n);
    logic [CH_W-1:0] text[$];
    logic [CH_W-1:0] c;
    int   eff;
    int   d;
    int   n_dig;
    bit   well_formed;
    logic start;
    well_formed = ($urandom_range(0, 9) > 1);
    if (!well_formed) begin
      repeat ($urandom_range(1, 6)) text.push_back(CH_W'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          d = $urandom_range(8, 13);
          text.push_back((d == 8) ? CH_SPACE : CH_W'(d));
        end
      end
      case ($urandom_range(0, 2))
        1: text.push_back(CH_PLUS);
        2: text.push_back(CH_MINUS);
        default: ;
      endcase
      eff = (radix < 2 || radix > BASE_LIMIT) ? 10 : radix;
      if ((radix == RADIX_AUTO || radix == RADIX_HEX) && $urandom_range(0, 2) == 0) begin
        text.push_back(CH_ZERO);
        text.push_back($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
        eff = 16;
      end else if (radix == RADIX_AUTO && $urandom_range(0, 3) == 0) begin
        text.push_back(CH_ZERO);
        eff = 8;
      end
      case ($urandom_range(0, 9))
        0: n_dig = $urandom_range(30, 36);
        1, 2: n_dig = $urandom_range(8, 14);
        default: n_dig = $urandom_range(0, 7);
      endcase
      for (int i = 0; i < n_dig; i++) begin
        d = $urandom_range(0, eff - 1);
        c = CH_W'((d < 10) ? CH_ZERO + d :
                  ($urandom_range(0, 1) ? CH_LO_A : CH_UP_A) + d - 10);
        text.push_back(c);
      end
      if ($urandom_range(0, 7) != 0) begin
        do c = CH_W'($urandom_range(0, 255));
        while (conversion_scoreboard::char_digit(c) < eff);
        text.push_back(c);
      end
    end
    for (int i = 0; i < text.size(); i++) begin
      if (well_formed) start = (i == 0);
      else start = (i == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 7) == 0);
      push_char(text[i], start);
    end
    n = text.size();
  endtask

  initial begin : receiver
    int tick;
    int mode;
    tick = 0;
    mode = 0;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        if (tick % 64 == 0) mode = $urandom_range(0, 3);
        tick++;
        case (mode)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= 1'($urandom_range(0, 1));
          2: out_if.ready <= ($urandom_range(0, 7) == 0);
          default: out_if.ready <= tick[2];
        endcase
        @(posedge clk_i);
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni === 1'b1 && out_if.valid && out_if.ready) begin
      sb.check_result(out_if.value, out_if.end_offset, out_if.status);
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    forever begin
      @(negedge clk_i);
      if (rst_ni !== 1'b1 || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
      if (idle >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [RADIX_W-1:0] plan[11];
    int sent;
    int n;
    int budget;
    rst_ni              <= 1'b0;
    in_if.valid         <= 1'b0;
    in_if.ch            <= '0;
    in_if.start_req     <= 1'b0;
    cfg_if.valid        <= 1'b0;
    cfg_if.radix_select <= RADIX_AUTO;
    burst_left = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_radix(RADIX_AUTO);
    send_str(" \t-0x1fA;");
    send_str("0xg");
    send_str("0777 ");
    send_str("+,");
    send_str("-");
    push_char(8'h00, 1'b0);
    send_str("4294967295;");
    send_str("4294967296;");
    send_str("12");
    send_str("7");
    push_char(8'hFF, 1'b0);
    push_char("5", 1'b0);
    push_char(8'h80, 1'b0);
    send_str(" ");
    repeat (40) push_char(CH_SPACE, 1'b0);
    push_char(CH_ZERO, 1'b0);
    push_char(CH_LO_X, 1'b0);
    push_char("!", 1'b0);

    settle();
    write_radix(RADIX_HEX);
    send_str("0X7fffffff ");
    send_str("fFfFfFfF0,");
    settle();
    write_radix(6'd2);
    send_str("-101b");
    settle();
    write_radix(BASE_LIMIT);
    send_str("zzzzzzz,");
    send_str("Zz.");
    settle();
    write_radix(RADIX_OCT);
    send_str("789");
    settle();
    write_radix(RADIX_DEC);
    send_str("\n");
    repeat (40) push_char(CH_SPACE, 1'b0);
    push_char("4", 1'b0);
    push_char("2", 1'b0);
    push_char(";", 1'b0);
    settle();
    write_radix(RADIX_BAD);
    send_str("5");
    settle();
    write_radix(6'd63);
    send_str("5");

    plan = '{RADIX_AUTO, RADIX_DEC, RADIX_HEX, 6'd2, BASE_LIMIT, RADIX_OCT,
             RADIX_BAD, 6'd63, 6'd37, RADIX_AUTO, RADIX_AUTO};
    plan[9] = RADIX_W'($urandom_range(2, 36));
    foreach (plan[p]) begin
      settle();
      write_radix(plan[p]);
      if (p == 1) hold_off_req = 1'b1;
      budget = (plan[p] == RADIX_BAD || plan[p] > BASE_LIMIT) ? BAD_PHASE_CHARS : PHASE_CHARS;
      sent = 0;
      while (sent < budget) begin
        send_random_string(plan[p], n);
        sent += n;
      end
    end

    settle();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ ascii_to_unsigned_parser_core.f @@
hw/rtl/atu_pkg.sv
hw/rtl/atu_if.sv
hw/rtl/atu_in_reg.sv
hw/rtl/atu_conv.sv
hw/rtl/atu_out_reg.sv
hw/rtl/ascii_to_unsigned_parser_core.sv
tb/sv/tb_top.sv
